// ===== sv/c2s_pkg.sv =====
// c2s_pkg: types, constants and arithmetic helpers for cartesian_to_spherical
// no dependencies

package c2s_pkg;

    localparam int COORD_WIDTH_DEF   = 32;
    localparam int CORDIC_STAGES_DEF = 32;
    localparam int ACC_W             = 64;
    localparam int ANG_SHIFT         = 30;
    localparam logic [63:0] HALF_PI_A = 64'sh1000_0000_0000_0000;
    localparam logic [63:0] INV_PI_Q64 = 64'h517CC1B727220A95;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic signed [31:0] y_coord;
        logic signed [31:0] z_coord;
    } c2s_in_t;

    typedef struct packed {
        logic [31:0]        radius;
        logic signed [31:0] right_ascension;
        logic signed [31:0] declination;
        logic [31:0]        co_declination;
        logic               zero_vector_error;
    } c2s_out_t;

    // per-item side information carried along the chain
    typedef struct packed {
        logic        axis;
        logic        zero;
        logic [31:0] axis_mag;
        logic        z_neg;
    } c2s_tag_t;

    function automatic logic [63:0] mulhi64(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        begin
            p = a * b;
            return p[127:64];
        end
    endfunction

    // restoring long division, used only for elaboration-time constants
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        begin
            q = '0;
            r = '0;
            for (int b = 63; b >= 0; b--) begin
                r = {r[63:0], n[b]};
                if (r >= {1'b0, d}) begin
                    r = r - {1'b0, d};
                    q[b] = 1'b1;
                end
            end
            return q;
        end
    endfunction

    function automatic logic signed [63:0] atan_const(input int i);
        logic signed [63:0] a;
        logic signed [63:0] term;
        int e;
        begin
            a = 0;
            if (i == 0) begin
                return 64'sd1 <<< 59;
            end
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e >= 0) begin
                    term = udiv64(64'd1 << e, 64'(2 * k + 1));
                    a = k[0] ? a - term : a + term;
                end
            end
            return 64'((mulhi64(64'(a), INV_PI_Q64) + 64'd1) >> 1);
        end
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_m;
        begin
            v = v_in;
            res = 0;
            bit_m = 64'd1 << 62;
            while (bit_m > v) bit_m = bit_m >> 2;
            while (bit_m != 0) begin
                if (v >= res + bit_m) begin
                    v = v - (res + bit_m);
                    res = (res >> 1) + bit_m;
                end else begin
                    res = res >> 1;
                end
                bit_m = bit_m >> 2;
            end
            return res;
        end
    endfunction

    function automatic logic [31:0] inv_gain_q32(input int stages);
        logic [63:0] k2;
        logic [63:0] k31;
        logic [63:0] q;
        begin
            k2 = 64'd1 << 62;
            for (int i = 0; i < stages; i++) begin
                if (2 * i < 64) k2 = k2 + (k2 >> (2 * i));
            end
            k31 = isqrt64(k2);
            if (k31 == 0) k31 = 1;
            q = udiv64((64'd1 << 63) + (k31 >> 1), k31);
            return q[31:0];
        end
    endfunction

endpackage

// ===== sv/c2s_cell.sv =====
// c2s_cell: one registered cordic vectoring micro-rotation
// depends on c2s_pkg

module c2s_cell #(
    parameter int                 SHIFT = 0,
    parameter logic signed [63:0] ATAN  = 64'sd0,
    parameter int                 PW    = 1
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  logic signed [63:0]   x_in,
    input  logic signed [63:0]   y_in,
    input  logic signed [63:0]   acc_in,
    input  logic [PW-1:0]        pass_in,
    output logic                 valid_out,
    output logic signed [63:0]   x_out,
    output logic signed [63:0]   y_out,
    output logic signed [63:0]   acc_out,
    output logic [PW-1:0]        pass_out
);
    import c2s_pkg::*;

    logic signed [63:0] x_next, y_next, acc_next;
    logic valid_reg;
    logic signed [63:0] x_reg, y_reg, acc_reg;
    logic [PW-1:0] pass_reg;

    always_comb begin
        if (!y_in[63]) begin
            x_next   = x_in + (y_in >>> SHIFT);
            y_next   = y_in - (x_in >>> SHIFT);
            acc_next = acc_in + ATAN;
        end else begin
            x_next   = x_in - (y_in >>> SHIFT);
            y_next   = y_in + (x_in >>> SHIFT);
            acc_next = acc_in - ATAN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            acc_reg  <= acc_next;
            pass_reg <= pass_in;
        end
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign y_out     = y_reg;
    assign acc_out   = acc_reg;
    assign pass_out  = pass_reg;

endmodule

// ===== sv/c2s_chain.sv =====
// c2s_chain: row of cordic cells plus gain correction multiply
// depends on c2s_pkg, c2s_cell

module c2s_chain #(
    parameter int STAGES = c2s_pkg::CORDIC_STAGES_DEF,
    parameter int PW     = 1
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  logic signed [63:0] x_in,
    input  logic signed [63:0] y_in,
    input  logic signed [63:0] acc_in,
    input  logic [PW-1:0]      pass_in,
    output logic               valid_out,
    output logic [63:0]        mag_out,
    output logic signed [63:0] acc_out,
    output logic [PW-1:0]      pass_out
);
    import c2s_pkg::*;

    localparam logic [31:0] INV_K = inv_gain_q32(STAGES);

    logic               v_w   [0:STAGES];
    logic signed [63:0] x_w   [0:STAGES];
    logic signed [63:0] y_w   [0:STAGES];
    logic signed [63:0] a_w   [0:STAGES];
    logic [PW-1:0]      p_w   [0:STAGES];

    assign v_w[0] = valid_in;
    assign x_w[0] = x_in;
    assign y_w[0] = y_in;
    assign a_w[0] = acc_in;
    assign p_w[0] = pass_in;

    for (genvar i = 0; i < STAGES; i++) begin : g_cell
        c2s_cell #(.SHIFT(i), .ATAN(atan_const(i)), .PW(PW)) u_cell (
            .aclk(aclk), .aresetn(aresetn), .en(en),
            .valid_in(v_w[i]), .x_in(x_w[i]), .y_in(y_w[i]),
            .acc_in(a_w[i]), .pass_in(p_w[i]),
            .valid_out(v_w[i+1]), .x_out(x_w[i+1]), .y_out(y_w[i+1]),
            .acc_out(a_w[i+1]), .pass_out(p_w[i+1])
        );
    end

    // gain correction in two 32x32 partial products
    logic [31:0]        xh, xl;
    logic [63:0]        ph_reg, pl_reg;
    logic signed [63:0] acc_reg;
    logic [PW-1:0]      pass_reg;
    logic               v1_reg;
    logic [63:0]        mag_reg;
    logic signed [63:0] acc2_reg;
    logic [PW-1:0]      pass2_reg;
    logic               v2_reg;

    always_comb begin
        if (x_w[STAGES] > 0) begin
            xh = x_w[STAGES][63:32];
            xl = x_w[STAGES][31:0];
        end else begin
            xh = '0;
            xl = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= v_w[STAGES];
            v2_reg <= v1_reg;
        end
        if (en) begin
            ph_reg    <= xh * INV_K;
            pl_reg    <= xl * INV_K;
            acc_reg   <= a_w[STAGES];
            pass_reg  <= p_w[STAGES];
            mag_reg   <= ph_reg + ((pl_reg + 64'h8000_0000) >> 32);
            acc2_reg  <= acc_reg;
            pass2_reg <= pass_reg;
        end
    end

    assign valid_out = v2_reg;
    assign mag_out   = mag_reg;
    assign acc_out   = acc2_reg;
    assign pass_out  = pass2_reg;

endmodule

// ===== sv/cartesian_to_spherical.sv =====
// cartesian_to_spherical: two cordic vectoring chains in series
// throughput: one transfer per cycle; the pipeline advances unless the output stalls
// reset: synchronous active-low aresetn clears all valid flags
// depends on c2s_pkg, c2s_chain, c2s_cell

module cartesian_to_spherical #(
    parameter int COORD_WIDTH   = c2s_pkg::COORD_WIDTH_DEF,
    parameter int CORDIC_STAGES = c2s_pkg::CORDIC_STAGES_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  c2s_pkg::c2s_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output c2s_pkg::c2s_out_t m_data
);
    import c2s_pkg::*;

    localparam int FRAC  = 60 - COORD_WIDTH;
    localparam int CW    = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int TAGW  = $bits(c2s_tag_t);
    localparam int PW1   = TAGW + 64;
    localparam int PW2   = TAGW + 32;

    logic en;
    logic out_valid_reg;
    c2s_out_t out_reg;

    // pipeline runs when output register is free or being drained
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    logic signed [63:0] xs, ys, zs;
    logic signed [63:0] x0, y0, a0;
    c2s_tag_t tag_in;
    logic [63:0] zabs;

    always_comb begin
        xs = 64'(signed'(s_data.x_coord[CW-1:0]));
        ys = 64'(signed'(s_data.y_coord[CW-1:0]));
        zs = 64'(signed'(s_data.z_coord[CW-1:0]));
        zabs = zs[63] ? 64'(-zs) : zs;
        tag_in.axis     = (xs == 0) && (ys == 0);
        tag_in.zero     = tag_in.axis && (zs == 0);
        tag_in.axis_mag = (zabs > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : zabs[31:0];
        tag_in.z_neg    = zs[63];
        xs = xs <<< FRAC;
        ys = ys <<< FRAC;
        zs = zs <<< FRAC;
        x0 = xs;
        y0 = ys;
        a0 = '0;
        if (xs[63]) begin
            if (!ys[63]) begin
                x0 = ys; y0 = -xs; a0 = HALF_PI_A;
            end else begin
                x0 = -ys; y0 = xs; a0 = -HALF_PI_A;
            end
        end
    end

    logic               v1;
    logic [63:0]        rho;
    logic signed [63:0] acc1;
    logic [PW1-1:0]     p1;

    c2s_chain #(.STAGES(CORDIC_STAGES), .PW(PW1)) u_pass1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .valid_in(s_valid), .x_in(x0), .y_in(y0), .acc_in(a0),
        .pass_in({tag_in, zs}),
        .valid_out(v1), .mag_out(rho), .acc_out(acc1), .pass_out(p1)
    );

    logic signed [63:0] ra_full;
    logic [31:0]        ra;
    assign ra_full = (acc1 + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
    assign ra      = ra_full[31:0];

    logic               v2;
    logic [63:0]        rr;
    logic signed [63:0] acc2;
    logic [PW2-1:0]     p2;

    c2s_chain #(.STAGES(CORDIC_STAGES), .PW(PW2)) u_pass2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .valid_in(v1), .x_in(signed'(rho)), .y_in(p1[63:0]), .acc_in('0),
        .pass_in({p1[PW1-1:64], ra}),
        .valid_out(v2), .mag_out(rr), .acc_out(acc2), .pass_out(p2)
    );

    c2s_tag_t tag_o;
    logic signed [63:0] accc, dec_full;
    logic [63:0] rad_full;
    c2s_out_t res;

    always_comb begin
        tag_o = p2[PW2-1:32];
        accc = acc2;
        if (accc > signed'(HALF_PI_A)) accc = HALF_PI_A;
        if (accc < -signed'(HALF_PI_A)) accc = -HALF_PI_A;
        dec_full = (accc + (64'sd1 <<< (ANG_SHIFT - 1))) >>> ANG_SHIFT;
        rad_full = (rr + (64'd1 << (FRAC - 1))) >> FRAC;
        res.radius = (rad_full > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rad_full[31:0];
        res.right_ascension   = p2[31:0];
        res.declination       = dec_full[31:0];
        res.co_declination    = 32'(32'sd1073741824 - dec_full[31:0]);
        res.zero_vector_error = 1'b0;
        if (tag_o.axis) begin
            res.radius          = tag_o.axis_mag;
            res.right_ascension = '0;
            res.zero_vector_error = tag_o.zero;
            if (tag_o.zero) begin
                res.declination    = '0;
                res.co_declination = '0;
            end else if (!tag_o.z_neg) begin
                res.declination    = 32'h4000_0000;
                res.co_declination = '0;
            end else begin
                res.declination    = 32'hC000_0000;
                res.co_declination = 32'h8000_0000;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v2;
        end
        if (en) begin
            out_reg <= res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input blocked with empty output");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.zero_vector_error |-> m_data.radius == 0)
        else $error("zero vector with nonzero radius");
    a_codec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.zero_vector_error |->
        m_data.co_declination == 32'(32'h4000_0000 - m_data.declination))
        else $error("co-declination mismatch");

endmodule

// ===== verif/cartesian_to_spherical_tb.sv =====
// cartesian_to_spherical_tb: self-checking testbench for the cartesian to spherical converter
// drives vectors through valid/ready, predicts each result with a bit-exact cordic model
// depends on c2s_pkg and cartesian_to_spherical

module cartesian_to_spherical_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import c2s_pkg::*;

    localparam int STAGES     = 32;
    localparam int FRAC       = 28;
    localparam int LATENCY    = 2 * STAGES + 7;
    localparam int WDOG_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        c2s_in_t  vec;
        bit       known;
        c2s_out_t res;
    } dir_row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    c2s_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    c2s_out_t m_data;

    c2s_out_t  sph_expected_q[$];
    dir_row_t  dir_rows[$];
    longint    atan_bau[STAGES];
    bit [63:0] inv_gain;
    int        src_idle_pct = 0;
    int        rx_stall_pct = 0;
    bit        rx_hold = 1'b0;
    int        errors = 0;
    int        idle_cycles = 0;

    cartesian_to_spherical dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #2 aclk = ~aclk;

    function automatic bit [63:0] hi_mul(bit [63:0] a, bit [63:0] b);
        bit [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[127:64];
    endfunction

    function automatic bit [63:0] int_sqrt(bit [63:0] v);
        bit [63:0] res;
        bit [63:0] b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic bit [63:0] scale_q32(bit [63:0] v, bit [63:0] c);
        bit [63:0] vh;
        bit [63:0] vl;
        vh = v >> 32;
        vl = v & 64'hFFFF_FFFF;
        return vh * c + ((vl * c + 64'h8000_0000) >> 32);
    endfunction

    function automatic void build_cordic_consts();
        longint a;
        longint term;
        int e;
        bit [63:0] k2;
        bit [63:0] k31;
        atan_bau[0] = 64'sd1 <<< 59;
        for (int i = 1; i < STAGES; i++) begin
            a = 0;
            for (int k = 0; k < 64; k++) begin
                e = 62 - i * (2 * k + 1);
                if (e < 0) break;
                term = (64'sd1 <<< e) / longint'(2 * k + 1);
                a = (k % 2 == 1) ? a - term : a + term;
            end
            atan_bau[i] = longint'((hi_mul(a, INV_PI_Q64) + 64'd1) >> 1);
        end
        k2 = 64'd1 << 62;
        for (int i = 0; i < STAGES; i++) begin
            if (2 * i < 64) k2 = k2 + (k2 >> (2 * i));
        end
        k31 = int_sqrt(k2);
        if (k31 == 0) k31 = 1;
        inv_gain = ((64'd1 << 63) + k31 / 2) / k31;
    endfunction

    function automatic void cordic_vector(inout longint px, inout longint py, inout longint acc);
        longint dx;
        longint dy;
        for (int i = 0; i < STAGES; i++) begin
            dx = py >>> i;
            dy = px >>> i;
            if (py >= 0) begin
                px = px + dx; py = py - dy; acc = acc + atan_bau[i];
            end else begin
                px = px - dx; py = py + dy; acc = acc - atan_bau[i];
            end
        end
    endfunction

    function automatic c2s_out_t spherical_of(c2s_in_t v);
        c2s_out_t o;
        longint x;
        longint y;
        longint z;
        longint bx;
        longint by;
        longint t;
        longint acc;
        longint acc2;
        longint ra;
        longint dec;
        longint rr;
        longint zz;
        bit [63:0] mag;
        bit [63:0] rho;
        bit [63:0] r;
        bit [63:0] rad;
        o = '0;
        x = longint'(v.x_coord);
        y = longint'(v.y_coord);
        z = longint'(v.z_coord);
        if (x == 0 && y == 0) begin
            mag = z < 0 ? -z : z;
            o.radius = mag[31:0];
            if (z == 0) begin
                o.zero_vector_error = 1'b1;
            end else if (z > 0) begin
                o.declination = 32'sh4000_0000;
            end else begin
                o.declination = 32'shC000_0000;
                o.co_declination = 32'h8000_0000;
            end
            return o;
        end
        bx = x <<< FRAC;
        by = y <<< FRAC;
        acc = 0;
        if (bx < 0) begin
            t = bx;
            if (by >= 0) begin
                bx = by; by = -t; acc = HALF_PI_A;
            end else begin
                bx = -by; by = t; acc = -longint'(HALF_PI_A);
            end
        end
        cordic_vector(bx, by, acc);
        ra = (acc + (64'sd1 <<< 29)) >>> 30;
        rho = scale_q32(bx > 0 ? bx : 0, inv_gain);
        rr = longint'(rho);
        zz = z <<< FRAC;
        acc2 = 0;
        cordic_vector(rr, zz, acc2);
        if (acc2 > longint'(HALF_PI_A)) acc2 = HALF_PI_A;
        if (acc2 < -longint'(HALF_PI_A)) acc2 = -longint'(HALF_PI_A);
        dec = (acc2 + (64'sd1 <<< 29)) >>> 30;
        r = scale_q32(rr > 0 ? rr : 0, inv_gain);
        rad = (r + (64'd1 << (FRAC - 1))) >> FRAC;
        if (rad > 64'hFFFF_FFFF) rad = 64'hFFFF_FFFF;
        o.radius = rad[31:0];
        o.right_ascension = ra[31:0];
        o.declination = dec[31:0];
        o.co_declination = 32'((64'sd1 <<< 30) - dec);
        return o;
    endfunction

    function automatic logic signed [31:0] rand_coord();
        logic signed [31:0] c;
        case ($urandom_range(5))
            0, 1: c = $urandom;
            2: c = $urandom >> $urandom_range(31);
            3: c = -($urandom >> $urandom_range(31));
            4: c = $signed($urandom_range(2000)) - 1000;
            default: begin
                case ($urandom_range(4))
                    0: c = 32'sh8000_0000;
                    1: c = 32'sh7FFF_FFFF;
                    2: c = -1;
                    3: c = 1;
                    default: c = 0;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic c2s_in_t rand_vector();
        c2s_in_t v;
        v.x_coord = rand_coord();
        v.y_coord = rand_coord();
        v.z_coord = rand_coord();
        case ($urandom_range(9))
            0: begin
                v.x_coord = 0;
                v.y_coord = 0;
                if ($urandom_range(3) == 0) v.z_coord = 0;
            end
            1: begin
                v.x_coord = -($urandom_range(32'h7FFF_FFFF) + 1);
                v.y_coord = $signed($urandom_range(6)) - 3;
            end
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_vector(c2s_in_t v);
        if ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < src_idle_pct) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= v;
        do @(posedge aclk); while (!s_ready);
        sph_expected_q.push_back(spherical_of(v));
        @(negedge aclk);
    endtask

    task automatic hold_receiver(int cycles);
        rx_hold = 1'b1;
        repeat (cycles) @(negedge aclk);
        rx_hold = 1'b0;
    endtask

    always @(negedge aclk) begin
        m_ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= rx_stall_pct);
    end

    always @(posedge aclk) begin
        c2s_out_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (sph_expected_q.size() == 0) begin
                $display("%0t: unexpected result radius=%h", $time, m_data.radius);
                errors++;
            end else begin
                exp_res = sph_expected_q.pop_front();
                if (m_data.radius !== exp_res.radius) begin
                    $display("%0t: radius expected %h got %h", $time,
                             exp_res.radius, m_data.radius);
                    errors++;
                end
                if (m_data.right_ascension !== exp_res.right_ascension) begin
                    $display("%0t: right_ascension expected %h got %h", $time,
                             exp_res.right_ascension, m_data.right_ascension);
                    errors++;
                end
                if (m_data.declination !== exp_res.declination) begin
                    $display("%0t: declination expected %h got %h", $time,
                             exp_res.declination, m_data.declination);
                    errors++;
                end
                if (m_data.co_declination !== exp_res.co_declination) begin
                    $display("%0t: co_declination expected %h got %h", $time,
                             exp_res.co_declination, m_data.co_declination);
                    errors++;
                end
                if (m_data.zero_vector_error !== exp_res.zero_vector_error) begin
                    $display("%0t: zero_vector_error expected %b got %b", $time,
                             exp_res.zero_vector_error, m_data.zero_vector_error);
                    errors++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (aresetn) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WDOG_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    task automatic add_row(int x, int y, int z, bit known, c2s_out_t res);
        dir_row_t row;
        row.vec = c2s_in_t'{x, y, z};
        row.known = known;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    initial begin
        int i_max;
        int i_min;
        c2s_out_t none;
        none = '0;
        i_max = 32'sh7FFF_FFFF;
        i_min = 32'sh8000_0000;
        build_cordic_consts();

        // zero vector and points on the z axis
        add_row(0, 0, 0, 1, c2s_out_t'{32'd0, 32'sd0, 32'sd0, 32'd0, 1'b1});
        add_row(0, 0, 5, 1, c2s_out_t'{32'd5, 32'sd0, 32'sh4000_0000, 32'd0, 1'b0});
        add_row(0, 0, -7, 1, c2s_out_t'{32'd7, 32'sd0, 32'shC000_0000, 32'h8000_0000, 1'b0});
        add_row(0, 0, i_min, 1,
                c2s_out_t'{32'h8000_0000, 32'sd0, 32'shC000_0000, 32'h8000_0000, 1'b0});
        add_row(0, 0, i_max, 1,
                c2s_out_t'{32'h7FFF_FFFF, 32'sd0, 32'sh4000_0000, 32'd0, 1'b0});
        // extremes, angles close to +-pi and small vectors
        add_row(i_max, i_max, i_max, 0, none);
        add_row(i_min, i_min, i_min, 0, none);
        add_row(i_min, 0, 0, 0, none);
        add_row(i_max, 0, 0, 0, none);
        add_row(0, i_max, 0, 0, none);
        add_row(0, i_min, 0, 0, none);
        add_row(-1, 0, 0, 0, none);
        add_row(-1000000, 1, 0, 0, none);
        add_row(-1000000, -1, 0, 0, none);
        add_row(1, 1, 1, 0, none);
        add_row(-1, -1, -1, 0, none);
        add_row(i_min, i_max, i_min, 0, none);
        add_row(1, 0, i_min, 0, none);
        add_row(i_max, i_min, i_max, 0, none);
        add_row(3, 4, 0, 0, none);
        add_row(1, 0, i_max, 0, none);

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (dir_rows[i]) begin
            send_vector(dir_rows[i].vec);
            if (dir_rows[i].known) begin
                void'(sph_expected_q.pop_back());
                sph_expected_q.push_back(dir_rows[i].res);
            end
        end

        // receiver held off while the sender keeps offering, fills the pipeline
        fork
            hold_receiver(HOLD_LEN);
        join_none
        for (int n = 0; n < 200; n++) send_vector(rand_vector());

        // sender pauses until everything has drained
        s_valid <= 1'b0;
        wait (sph_expected_q.size() == 0);
        @(negedge aclk);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin src_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin src_idle_pct = 85; rx_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  rx_stall_pct = 85; end
                default: begin src_idle_pct = 30; rx_stall_pct = 30; end
            endcase
            for (int n = 0; n < 330; n++) send_vector(rand_vector());
        end
        s_valid <= 1'b0;
        src_idle_pct = 0;
        rx_stall_pct = 0;

        wait (sph_expected_q.size() == 0);
        repeat (LATENCY + 10) @(posedge aclk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
